FILE: rtl/core/argb_pixel_combine_alu_assert.svh
// assertion macros shared by the pixel combine alu
`ifndef ARGB_PIXEL_COMBINE_ALU_ASSERT_SVH
`define ARGB_PIXEL_COMBINE_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define APCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define APCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define APCA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define APCA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/apca_pkg.sv
package apca_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_MUL   = 2'd0,
		OP_BLEND = 2'd1,
		OP_SUB   = 2'd2,
		OP_PASS  = 2'd3
	} op_t;

	localparam logic [7:0]  CH_MAX  = 8'd255;
	localparam logic [15:0] CH_HALF = 16'd127;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

	// floor(v / 255) for v below 65280, via reciprocal with correction
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = 17'(v) + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

FILE: rtl/core/apca_req_if.sv
interface apca_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] left_pixel;
	logic [31:0] right_pixel;

	modport source (output valid, output req_type, output left_pixel, output right_pixel,
		input ready);
	modport sink (input valid, input req_type, input left_pixel, input right_pixel,
		output ready);
endinterface

FILE: rtl/core/apca_rsp_if.sv
interface apca_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_pixel;

	modport source (output valid, output result_pixel, input ready);
	modport sink (input valid, input result_pixel, output ready);
endinterface

FILE: rtl/core/apca_chan_lane.sv
module apca_chan_lane (
	input  logic                clk,
	input  apca_pkg::stage_en_t en,
	input  apca_pkg::op_t       op_s0,
	input  apca_pkg::op_t       op_s2,
	input  logic                alpha_lane,
	input  logic [7:0]          weight,
	input  logic [7:0]          l_ch,
	input  logic [7:0]          r_ch,
	output logic [7:0]          res_ch
);

	logic        blend_mix;
	logic [7:0]  ma;
	logic [7:0]  mb;
	logic [15:0] pa;
	logic [15:0] pb;

	logic [7:0]  l_s1;
	logic [7:0]  r_s1;
	logic [15:0] pa_s1;
	logic [15:0] pb_s1;

	logic [7:0]  l_s2;
	logic [7:0]  r_s2;
	logic [15:0] sum_s2;

	logic [8:0]  alpha_sum;
	logic [7:0]  alpha_sat;
	logic [7:0]  diff;
	logic [7:0]  quot;
	logic [7:0]  res_nxt;
	logic [7:0]  res_s3;

	// product stage: color lanes of a blend take the two lerp terms
	always_comb begin
		blend_mix = (op_s0 == apca_pkg::OP_BLEND) && !alpha_lane;
		ma = blend_mix ? 8'(apca_pkg::CH_MAX - weight) : l_ch;
		mb = blend_mix ? l_ch : r_ch;
		pa = 16'(ma) * 16'(mb);
		pb = blend_mix ? 16'(weight) * 16'(r_ch) : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			l_s1  <= l_ch;
			r_s1  <= r_ch;
			pa_s1 <= pa;
			pb_s1 <= pb;
		end
	end

	// sum stage with rounding bias
	always_ff @(posedge clk) begin
		if (en.en2) begin
			l_s2   <= l_s1;
			r_s2   <= r_s1;
			sum_s2 <= pa_s1 + pb_s1 + apca_pkg::CH_HALF;
		end
	end

	// divide by 255 and pick the operation result
	always_comb begin
		alpha_sum = 9'(l_s2) + 9'(r_s2);
		alpha_sat = alpha_sum[8] ? apca_pkg::CH_MAX : alpha_sum[7:0];
		diff      = (l_s2 > r_s2) ? 8'(l_s2 - r_s2) : 8'd0;
		quot      = apca_pkg::div255(sum_s2);
		unique case (op_s2)
			apca_pkg::OP_MUL:   res_nxt = quot;
			apca_pkg::OP_BLEND: res_nxt = alpha_lane ? alpha_sat : quot;
			apca_pkg::OP_SUB:   res_nxt = diff;
			apca_pkg::OP_PASS:  res_nxt = l_s2;
			default:            res_nxt = l_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			res_s3 <= res_nxt;
		end
	end

	assign res_ch = res_s3;

endmodule

FILE: rtl/core/argb_pixel_combine_alu.sv
// ARGB pixel combine ALU
// req channel (sink): req_type, left_pixel, right_pixel; one transaction per pixel pair.
// rsp channel (source): result_pixel; exactly one transaction per accepted request,
// in request order.
// req_type: multiply, alpha blend add (weight is the right alpha), saturating
// subtract, or pass the left pixel through unchanged.
// Pipeline: product, sum and divide stages from request acceptance to rsp.valid;
// the divide stage output is the result register. Throughput: one pixel per cycle
// while rsp.ready is high; each channel has its own two 8x8 multipliers.
// Stalls: each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up while rsp.ready is low and req.ready drops only once all three
// stages hold a transaction.
// Reset: arst_n clears the stage valid bits; the pipeline comes out empty and
// ready at once.
`include "argb_pixel_combine_alu_assert.svh"

module argb_pixel_combine_alu (
	input  logic       clk,
	input  logic       arst_n,
	apca_req_if.sink   req,
	apca_rsp_if.source rsp
);

	apca_pkg::stage_en_t en;
	apca_pkg::op_t       op_s0;
	apca_pkg::op_t       op_s1;
	apca_pkg::op_t       op_s2;
	logic                vld_s1;
	logic                vld_s2;
	logic                vld_s3;
	logic [3:0][7:0]     res_ch;

	// stage enables
	always_comb begin
		en.en3 = !vld_s3 || rsp.ready;
		en.en2 = !vld_s2 || en.en3;
		en.en1 = !vld_s1 || en.en2;
	end

	assign req.ready = en.en1;
	assign op_s0     = apca_pkg::op_t'(req.req_type);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en.en1) vld_s1 <= req.valid;
			if (en.en2) vld_s2 <= vld_s1;
			if (en.en3) vld_s3 <= vld_s2;
		end
	end

	// operation code pipeline
	always_ff @(posedge clk) begin
		if (en.en1) op_s1 <= op_s0;
		if (en.en2) op_s2 <= op_s1;
	end

	// one lane per channel, alpha in the top lane
	for (genvar i = 0; i < 4; i++) begin : g_lane
		apca_chan_lane u_lane (
			.clk        (clk),
			.en         (en),
			.op_s0      (op_s0),
			.op_s2      (op_s2),
			.alpha_lane (i == 3),
			.weight     (req.right_pixel[31:24]),
			.l_ch       (req.left_pixel[8*i +: 8]),
			.r_ch       (req.right_pixel[8*i +: 8]),
			.res_ch     (res_ch[i])
		);
	end

	assign rsp.valid        = vld_s3;
	assign rsp.result_pixel = res_ch;

	// backpressure only when every stage is full and the output is stalled
	`APCA_ASSERT_IMP(a_ready_full, clk, arst_n, !req.ready, vld_s1 && vld_s2 && vld_s3 && !rsp.ready)
	// occupancy grows by one on an input-only transaction
	`APCA_ASSERT_NXT(a_occ_up, clk, arst_n, req.valid && req.ready && !(rsp.valid && rsp.ready), $countones({vld_s1, vld_s2, vld_s3}) == $past($countones({vld_s1, vld_s2, vld_s3})) + 1)
	// occupancy shrinks by one on an output-only transaction
	`APCA_ASSERT_NXT(a_occ_dn, clk, arst_n, !(req.valid && req.ready) && rsp.valid && rsp.ready, $countones({vld_s1, vld_s2, vld_s3}) + 1 == $past($countones({vld_s1, vld_s2, vld_s3})))

endmodule
